// ----- src/mftfc_pkg.sv -----
// Shared types and constants of the masked five-tuple flow classifier.
package mftfc_pkg;

    localparam int NUM_ENTRIES = 7;
    localparam int PROF_W      = 6;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_STAGE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_NOT_FOUND,
        RES_ALLOC,
        RES_HIT
    } res_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0]       src_key_hi;
        logic [63:0]       src_key_lo;
        logic [63:0]       src_mask_hi;
        logic [63:0]       src_mask_lo;
        logic [63:0]       dst_key_hi;
        logic [63:0]       dst_key_lo;
        logic [63:0]       dst_mask_hi;
        logic [63:0]       dst_mask_lo;
        logic [15:0]       sport;
        logic [15:0]       sp_mask;
        logic [15:0]       dport;
        logic [15:0]       dp_mask;
        logic [3:0]        port;
        logic              fam;
        logic [7:0]        proto;
        logic              proto_en;
        logic [PROF_W-1:0] profile;
        logic [63:0]       cookie;
    } entry_t;

    typedef struct packed {
        logic     capture;
        logic     stage;
        logic     insert;
        logic     idx_clr;
        logic     idx_inc;
        logic     rd_en;
        logic     rd_next;
        logic     shift_wr;
        logic     free_prof;
        logic     count_dec;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    full;
        logic    cnt_zero;
        logic    hit;
        logic    more;
        logic    shift_more;
        logic    out_free;
    } sts_t;

endpackage

// ----- src/masked_five_tuple_flow_classifier_unit.sv -----
// Top level of the masked five-tuple flow classifier.
// Input channel: in_valid/in_stall carry one transaction with an action (lookup,
// stage masks, insert filter, remove filter) and the flow or filter fields.
// Output channel: out_valid/out_stall carry one transaction per input with
// profile_number and status.
// A transaction is taken only while the controller is idle; in_stall is high
// otherwise. Stage masks and insert pass from the decode state straight to the
// finish state. Lookup walks the table in order, with a read state and a
// compare state for each entry visited through the single table read port.
// Remove walks the same way, then compacts the list with a shift read state
// and a shift write state for each entry moved.
// A finished result sits in the output register; the next transaction may be
// taken while it waits. If out_stall holds the previous result, the new result
// waits in the controller until the register frees.
// Reset clears the entry count, profile allocation, staged masks and output
// valid; the table holds no filters after reset.
module masked_five_tuple_flow_classifier_unit
    import mftfc_pkg::*;
#(
    parameter int ENTRIES = NUM_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  in_port,
    input  logic        addr_family,
    input  logic [7:0]  ip_protocol,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [63:0] filter_cookie,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  profile_number,
    output logic [1:0]  status
);

    cmd_t cmd;
    sts_t sts;

    mftfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mftfc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .in_port        (in_port),
        .addr_family    (addr_family),
        .ip_protocol    (ip_protocol),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .src_addr_hi    (src_addr_hi),
        .src_addr_lo    (src_addr_lo),
        .dst_addr_hi    (dst_addr_hi),
        .dst_addr_lo    (dst_addr_lo),
        .filter_cookie  (filter_cookie),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .profile_number (profile_number),
        .status         (status),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ----- src/mftfc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mftfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/mftfc_ctrl.sv -----
// Controller state machine of the flow classifier.
module mftfc_ctrl
    import mftfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if ((sts.action inside {ACT_LOOKUP, ACT_REMOVE}) && !sts.cnt_zero)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.hit)
                begin
                    if (sts.action == ACT_REMOVE && sts.more)
                    begin
                        state_next = ST_SH_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (sts.more)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SH_RD:
            begin
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                state_next = sts.shift_more ? ST_SH_RD : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res_sel = RES_OK;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                cmd.idx_clr = 1'b1;
                case (sts.action)
                    ACT_STAGE:
                    begin
                        cmd.stage    = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_OK;
                    end
                    ACT_INSERT:
                    begin
                        cmd.res_load = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_sel = RES_FULL;
                        end
                        else
                        begin
                            cmd.insert  = 1'b1;
                            cmd.res_sel = RES_ALLOC;
                        end
                    end
                    default:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = (sts.action == ACT_LOOKUP) ? RES_OK : RES_NOT_FOUND;
                        end
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_HIT;
                    if (sts.action == ACT_REMOVE)
                    begin
                        cmd.free_prof = 1'b1;
                        cmd.count_dec = !sts.more;
                    end
                end
                else if (sts.more)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = (sts.action == ACT_LOOKUP) ? RES_OK : RES_NOT_FOUND;
                end
            end
            ST_SH_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
            end
            ST_SH_WR:
            begin
                cmd.shift_wr  = 1'b1;
                cmd.idx_inc   = 1'b1;
                cmd.count_dec = !sts.shift_more;
            end
            ST_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/mftfc_dp.sv -----
// Datapath of the flow classifier: filter table, masks, allocation and result register.
module mftfc_dp
    import mftfc_pkg::*;
#(
    parameter int ENTRIES = NUM_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  action,
    input  logic [3:0]  in_port,
    input  logic        addr_family,
    input  logic [7:0]  ip_protocol,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [63:0] filter_cookie,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [2:0]  profile_number,
    output logic [1:0]  status,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(entry_t);

    action_t        act_reg;
    logic [3:0]     port_reg;
    logic           fam_reg;
    logic [7:0]     proto_reg;
    logic [15:0]    sp_reg;
    logic [15:0]    dp_reg;
    logic [63:0]    sa_hi_reg, sa_lo_reg, da_hi_reg, da_lo_reg;
    logic [63:0]    cookie_reg;

    logic [63:0]    m_sa_hi_reg, m_sa_lo_reg, m_da_hi_reg, m_da_lo_reg;
    logic [15:0]    m_sp_reg, m_dp_reg;
    logic           m_proto_reg;

    logic [CW-1:0]      count_reg;
    logic [ENTRIES-1:0] busy_reg, busy_next;
    logic [CW-1:0]      idx_reg;

    logic               out_valid_reg;
    logic [PROF_W-1:0]  res_prof_reg;
    status_t            res_sts_reg;
    logic [PROF_W-1:0]  out_prof_reg;
    status_t            out_sts_reg;

    logic [PROF_W-1:0]  free_prof;
    logic               free_found;
    entry_t             new_rec;
    entry_t             rd_rec;
    logic [EW-1:0]      rdata;
    logic               lk_match;
    logic               rm_match;
    logic [CW:0]        idx_p1;
    logic [CW:0]        idx_p2;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;

    assign rd_rec = entry_t'(rdata);
    assign idx_p1 = {1'b0, idx_reg} + (CW + 1)'(1);
    assign idx_p2 = {1'b0, idx_reg} + (CW + 1)'(2);

    always_comb
    begin
        free_prof  = '0;
        free_found = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_prof  = PROF_W'(i + 1);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        new_rec             = '0;
        new_rec.src_key_hi  = fam_reg ? sa_hi_reg : 64'd0;
        new_rec.src_key_lo  = fam_reg ? sa_lo_reg : {32'd0, sa_lo_reg[31:0]};
        new_rec.src_mask_hi = fam_reg ? m_sa_hi_reg : 64'd0;
        new_rec.src_mask_lo = fam_reg ? m_sa_lo_reg : {32'd0, m_sa_lo_reg[31:0]};
        new_rec.dst_key_hi  = fam_reg ? da_hi_reg : 64'd0;
        new_rec.dst_key_lo  = fam_reg ? da_lo_reg : {32'd0, da_lo_reg[31:0]};
        new_rec.dst_mask_hi = fam_reg ? m_da_hi_reg : 64'd0;
        new_rec.dst_mask_lo = fam_reg ? m_da_lo_reg : {32'd0, m_da_lo_reg[31:0]};
        new_rec.sport       = sp_reg;
        new_rec.sp_mask     = m_sp_reg;
        new_rec.dport       = dp_reg;
        new_rec.dp_mask     = m_dp_reg;
        new_rec.port        = port_reg;
        new_rec.fam         = fam_reg;
        new_rec.proto       = proto_reg;
        new_rec.proto_en    = m_proto_reg;
        new_rec.profile     = free_prof;
        new_rec.cookie      = cookie_reg;
    end

    assign lk_match = (rd_rec.port == port_reg) && (rd_rec.fam == fam_reg)
        && (!rd_rec.proto_en || (rd_rec.proto == proto_reg))
        && (((sp_reg ^ rd_rec.sport) & rd_rec.sp_mask) == 16'd0)
        && (((dp_reg ^ rd_rec.dport) & rd_rec.dp_mask) == 16'd0)
        && (((sa_hi_reg ^ rd_rec.src_key_hi) & rd_rec.src_mask_hi) == 64'd0)
        && (((sa_lo_reg ^ rd_rec.src_key_lo) & rd_rec.src_mask_lo) == 64'd0)
        && (((da_hi_reg ^ rd_rec.dst_key_hi) & rd_rec.dst_mask_hi) == 64'd0)
        && (((da_lo_reg ^ rd_rec.dst_key_lo) & rd_rec.dst_mask_lo) == 64'd0);

    assign rm_match = (rd_rec.port == port_reg) && (rd_rec.cookie == cookie_reg);

    assign ram_we    = cmd.insert || cmd.shift_wr;
    assign ram_waddr = cmd.insert ? AW'(count_reg) : AW'(idx_reg);
    assign ram_raddr = cmd.rd_next ? AW'(idx_p1) : AW'(idx_reg);

    mftfc_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.insert ? EW'(new_rec) : rdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.insert)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (free_prof == PROF_W'(i + 1))
                begin
                    busy_next[i] = 1'b1;
                end
            end
        end
        if (cmd.free_prof)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (rd_rec.profile == PROF_W'(i + 1))
                begin
                    busy_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= action_t'(action);
            port_reg   <= in_port;
            fam_reg    <= addr_family;
            proto_reg  <= ip_protocol;
            sp_reg     <= source_port;
            dp_reg     <= dest_port;
            sa_hi_reg  <= src_addr_hi;
            sa_lo_reg  <= src_addr_lo;
            da_hi_reg  <= dst_addr_hi;
            da_lo_reg  <= dst_addr_lo;
            cookie_reg <= filter_cookie;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= CW'(idx_p1);
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_FULL:
                begin
                    res_prof_reg <= '0;
                    res_sts_reg  <= STS_FULL;
                end
                RES_NOT_FOUND:
                begin
                    res_prof_reg <= '0;
                    res_sts_reg  <= STS_NOT_FOUND;
                end
                RES_ALLOC:
                begin
                    res_prof_reg <= free_prof;
                    res_sts_reg  <= STS_OK;
                end
                RES_HIT:
                begin
                    res_prof_reg <= rd_rec.profile;
                    res_sts_reg  <= STS_OK;
                end
                default:
                begin
                    res_prof_reg <= '0;
                    res_sts_reg  <= STS_OK;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_prof_reg <= res_prof_reg;
            out_sts_reg  <= res_sts_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
            m_sa_hi_reg   <= '0;
            m_sa_lo_reg   <= '0;
            m_da_hi_reg   <= '0;
            m_da_lo_reg   <= '0;
            m_sp_reg      <= '0;
            m_dp_reg      <= '0;
            m_proto_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cmd.insert)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.stage)
            begin
                m_sa_hi_reg <= sa_hi_reg;
                m_sa_lo_reg <= sa_lo_reg;
                m_da_hi_reg <= da_hi_reg;
                m_da_lo_reg <= da_lo_reg;
                m_sp_reg    <= sp_reg;
                m_dp_reg    <= dp_reg;
                m_proto_reg <= (proto_reg != 8'd0);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.action     = act_reg;
    assign sts.full       = (count_reg >= CW'(ENTRIES)) || !free_found;
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.hit        = (act_reg == ACT_LOOKUP) ? lk_match : rm_match;
    assign sts.more       = idx_p1 < {1'b0, count_reg};
    assign sts.shift_more = idx_p2 < {1'b0, count_reg};
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign profile_number = out_prof_reg[2:0];
    assign status         = out_sts_reg;

endmodule

// ----- test/masked_five_tuple_flow_classifier_unit_tb.sv -----
// Testbench for the masked five-tuple flow classifier: directed and random checks on a scoreboard.
module masked_five_tuple_flow_classifier_unit_tb
    import mftfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = NUM_ENTRIES;

    typedef struct {
        logic [3:0]  port;
        logic        fam;
        logic [7:0]  proto;
        logic        proto_en;
        logic [15:0] sp, spm, dp, dpm;
        logic [63:0] sa_hi, sa_lo, sm_hi, sm_lo, da_hi, da_lo, dm_hi, dm_lo;
        logic [2:0]  prof;
        logic [63:0] cookie;
    } filter_t;

    typedef struct {
        logic [2:0] prof;
        logic [1:0] sts;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = '0;
    logic [3:0] in_port = '0;
    logic addr_family = 1'b0;
    logic [7:0] ip_protocol = '0;
    logic [15:0] source_port = '0, dest_port = '0;
    logic [63:0] src_addr_hi = '0, src_addr_lo = '0, dst_addr_hi = '0, dst_addr_lo = '0;
    logic [63:0] filter_cookie = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] profile_number;
    logic [1:0] status;

    filter_t acl[$];
    logic [NENT-1:0] busy_profiles;
    logic [63:0] stg_sm_hi, stg_sm_lo, stg_dm_hi, stg_dm_lo;
    logic [15:0] stg_spm, stg_dpm;
    logic stg_proto_en;
    verdict_t pending_verdicts[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [63:0] cookies[4];

    masked_five_tuple_flow_classifier_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL masked_five_tuple_flow_classifier_unit");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result profile_number=%0d status=%0d",
                       profile_number, status);
                errors++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (profile_number !== v.prof)
                begin
                    $error("profile_number expected %0d actual %0d", v.prof, profile_number);
                    errors++;
                end
                if (status !== v.sts)
                begin
                    $error("status expected %0d actual %0d", v.sts, status);
                    errors++;
                end
            end
        end
    end

    function automatic logic meq(logic [63:0] a, logic [63:0] k, logic [63:0] m);
        return (a & m) == (k & m);
    endfunction

    function automatic verdict_t classify(logic [1:0] act, logic [3:0] port, logic fam,
                                          logic [7:0] proto, logic [15:0] sp,
                                          logic [15:0] dp, logic [63:0] a0,
                                          logic [63:0] a1, logic [63:0] a2,
                                          logic [63:0] a3, logic [63:0] ck);
        verdict_t r;
        filter_t f;
        int n;
        r.prof = '0;
        r.sts = STS_OK;
        case (action_t'(act))
            ACT_LOOKUP:
                foreach (acl[i])
                begin
                    f = acl[i];
                    if (f.port == port && f.fam == fam && (!f.proto_en || f.proto == proto)
                        && meq(sp, f.sp, f.spm) && meq(dp, f.dp, f.dpm)
                        && meq(a0, f.sa_hi, f.sm_hi) && meq(a1, f.sa_lo, f.sm_lo)
                        && meq(a2, f.da_hi, f.dm_hi) && meq(a3, f.da_lo, f.dm_lo))
                    begin
                        r.prof = f.prof;
                        break;
                    end
                end
            ACT_STAGE:
            begin
                {stg_sm_hi, stg_sm_lo, stg_dm_hi, stg_dm_lo} = {a0, a1, a2, a3};
                stg_spm = sp;
                stg_dpm = dp;
                stg_proto_en = (proto != 8'd0);
            end
            ACT_INSERT:
                if (acl.size() >= NENT)
                    r.sts = STS_FULL;
                else
                begin
                    for (n = 1; n <= NENT; n++)
                        if (!busy_profiles[n-1])
                            break;
                    busy_profiles[n-1] = 1'b1;
                    r.prof = n[2:0];
                    f = '{port: port, fam: fam, proto: proto, proto_en: stg_proto_en,
                          sp: sp, spm: stg_spm, dp: dp, dpm: stg_dpm,
                          sa_hi: a0, sa_lo: a1, sm_hi: stg_sm_hi, sm_lo: stg_sm_lo,
                          da_hi: a2, da_lo: a3, dm_hi: stg_dm_hi, dm_lo: stg_dm_lo,
                          prof: n[2:0], cookie: ck};
                    if (!fam)
                    begin
                        f.sa_hi = '0; f.sm_hi = '0; f.da_hi = '0; f.dm_hi = '0;
                        f.sa_lo[63:32] = '0; f.sm_lo[63:32] = '0;
                        f.da_lo[63:32] = '0; f.dm_lo[63:32] = '0;
                    end
                    acl.push_back(f);
                end
            default:
            begin
                r.sts = STS_NOT_FOUND;
                for (int i = 0; i < acl.size(); i++)
                    if (acl[i].port == port && acl[i].cookie == ck)
                    begin
                        r.prof = acl[i].prof;
                        r.sts = STS_OK;
                        busy_profiles[acl[i].prof-1] = 1'b0;
                        acl.delete(i);
                        break;
                    end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] act, logic [3:0] port, logic fam, logic [7:0] proto,
                             logic [15:0] sp, logic [15:0] dp, logic [63:0] a0,
                             logic [63:0] a1, logic [63:0] a2, logic [63:0] a3,
                             logic [63:0] ck);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act; in_port <= port; addr_family <= fam; ip_protocol <= proto;
        source_port <= sp; dest_port <= dp;
        src_addr_hi <= a0; src_addr_lo <= a1; dst_addr_hi <= a2; dst_addr_lo <= a3;
        filter_cookie <= ck;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_verdicts.push_back(classify(act, port, fam, proto, sp, dp, a0, a1, a2, a3, ck));
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        logic [63:0] ones = '1;
        logic [63:0] zero = '0;
        send_item(ACT_LOOKUP, 4'd0, 1'b0, 8'd0, 16'd0, 16'd0, zero, zero, zero, zero, zero);
        send_item(ACT_REMOVE, 4'd15, 1'b1, 8'd255, '1, '1, ones, ones, ones, ones, ones);
        send_item(ACT_STAGE, 4'd0, 1'b0, 8'd6, '1, '1, ones, ones, ones, ones, zero);
        send_item(ACT_INSERT, 4'd3, 1'b0, 8'd6, 16'd80, 16'd443, ones, ones, ones, ones, 64'd1);
        send_item(ACT_LOOKUP, 4'd3, 1'b0, 8'd6, 16'd80, 16'd443, zero, ones, 64'd5, ones, zero);
        send_item(ACT_LOOKUP, 4'd3, 1'b0, 8'd17, 16'd80, 16'd443, zero, ones, zero, ones, zero);
        send_item(ACT_STAGE, 4'd0, 1'b1, 8'd0, 16'd0, 16'd0, ones, zero, ones, zero, zero);
        for (int i = 0; i < 7; i++)
            send_item(ACT_INSERT, 4'd15, 1'b1, 8'd255, '1, '1, ones, ones, ones, ones, 64'd9);
        send_item(ACT_LOOKUP, 4'd15, 1'b1, 8'd1, 16'd0, 16'd0, ones, zero, ones, zero, zero);
        send_item(ACT_REMOVE, 4'd15, 1'b0, 8'd0, 16'd0, 16'd0, zero, zero, zero, zero, 64'd9);
        send_item(ACT_REMOVE, 4'd3, 1'b0, 8'd0, 16'd0, 16'd0, zero, zero, zero, zero, 64'd1);
        send_item(ACT_INSERT, 4'd15, 1'b1, 8'd0, 16'd0, 16'd0, zero, zero, zero, zero, ones);
        send_item(ACT_LOOKUP, 4'd15, 1'b1, 8'd0, 16'd0, 16'd0, ones, zero, ones, zero, zero);
        for (int i = 0; i < 7; i++)
            send_item(ACT_REMOVE, 4'd15, 1'b0, 8'd0, 16'd0, 16'd0, zero, zero, zero, zero,
                      i < 6 ? 64'd9 : ones);
        go_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [1:0] act;
        logic [3:0] port;
        logic fam;
        logic [63:0] a0, a1, a2, a3;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            act = pick < 40 ? ACT_LOOKUP : pick < 50 ? ACT_STAGE : pick < 78 ? ACT_INSERT
                                                                   : ACT_REMOVE;
            if (pick < 25 && acl.size() > 0)
            begin
                filter_t f = acl[$urandom_range(acl.size() - 1)];
                a0 = f.sa_hi; a1 = f.sa_lo; a2 = f.da_hi; a3 = f.da_lo;
                if ($urandom_range(3) == 0) a1 ^= 64'd1 << $urandom_range(63);
                if (f.fam == 1'b0)
                begin
                    a0 = rnd64();
                    a1[63:32] = $urandom();
                end
                send_item(act, f.port, f.fam,
                          $urandom_range(3) == 0 ? 8'($urandom()) : f.proto,
                          f.sp ^ 16'(($urandom_range(3) == 0) << $urandom_range(15)),
                          f.dp, a0, a1, a2, a3, 64'd0);
                continue;
            end
            if (act == ACT_STAGE && $urandom_range(1))
                send_item(act, 4'($urandom()), 1'($urandom()),
                          $urandom_range(1) ? 8'($urandom()) : 8'd0,
                          $urandom_range(1) ? '1 : 16'($urandom()),
                          $urandom_range(1) ? 16'hFF00 : 16'($urandom()),
                          $urandom_range(1) ? '1 : rnd64(), rnd64(),
                          $urandom_range(1) ? 64'hFFFF_0000_0000_0000 : rnd64(), rnd64(),
                          64'd0);
            else if (act == ACT_REMOVE && acl.size() > 0 && $urandom_range(3) != 0)
            begin
                filter_t f = acl[$urandom_range(acl.size() - 1)];
                send_item(act, f.port, 1'($urandom()), 8'($urandom()), 16'($urandom()),
                          16'($urandom()), rnd64(), rnd64(), rnd64(), rnd64(), f.cookie);
            end
            else
            begin
                port = $urandom_range(3) == 0 ? 4'($urandom()) : 4'($urandom_range(1));
                fam = 1'($urandom());
                send_item(act, port, fam, 8'($urandom_range(3) ? $urandom_range(2) : $urandom()),
                          16'($urandom_range(1) ? $urandom_range(3) : $urandom()),
                          16'($urandom()), rnd64(), rnd64(), rnd64(), rnd64(),
                          $urandom_range(1) ? cookies[$urandom_range(3)] : rnd64());
            end
        end
        go_idle();
    endtask

    initial
    begin
        busy_profiles = '0;
        {stg_sm_hi, stg_sm_lo, stg_dm_hi, stg_dm_lo} = '0;
        stg_spm = '0; stg_dpm = '0; stg_proto_en = 1'b0;
        foreach (cookies[i]) cookies[i] = rnd64();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(450, 22, 88);
        test_random(450, 88, 22);
        test_random(450, 0, 0);
        recv_stall_pct = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS masked_five_tuple_flow_classifier_unit");
        else
            $display("FAIL masked_five_tuple_flow_classifier_unit");
        $finish;
    end
endmodule
